// ===== rtl/tlf_pkg.sv =====
`default_nettype none

package tlf_pkg;

    // Character codes that steer the folding.
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_BLANK   = 8'd32;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_EMIT_NL,
        ST_MOVE_RD,
        ST_MOVE_WR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the request on the input ports
        logic fill_step;  // store one blank of a tab
        logic emit_rd;    // read the line store at the emit index
        logic emit_load;  // put the read byte into the output register
        logic nl_load;    // put the closing newline into the output register
        logic move_rd;    // read the byte to be moved to the front
        logic move_wr;    // write the moved byte at the column
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_eoi;
        logic in_tab;
        logic in_nl;
        logic line_empty;
        logic col_full;      // column plus one reaches the line width
        logic fill_end;      // this blank ends the tab
        logic emit_last;     // emit index is at the last byte of the line
        logic move_last;     // move source is at the end of the store
        logic move_pending;  // a fold left a remainder to move
        logic out_free;      // output register can take a byte this cycle
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/tlf_ctrl.sv =====
`default_nettype none

module tlf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire tlf_pkg::status_t status,
    output tlf_pkg::cmd_t         cmd
);

    tlf_pkg::state_t state_reg;
    tlf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            tlf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_eoi || status.in_nl)
                    begin
                        if (!status.line_empty)
                        begin
                            state_next = tlf_pkg::ST_EMIT_RD;
                        end
                    end
                    else if (status.in_tab)
                    begin
                        state_next = tlf_pkg::ST_FILL;
                    end
                    else if (status.col_full)
                    begin
                        state_next = tlf_pkg::ST_EMIT_RD;
                    end
                end
            end
            tlf_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.col_full)
                begin
                    state_next = tlf_pkg::ST_EMIT_RD;
                end
                else if (status.fill_end)
                begin
                    state_next = tlf_pkg::ST_IDLE;
                end
            end
            tlf_pkg::ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = tlf_pkg::ST_EMIT_WR;
            end
            tlf_pkg::ST_EMIT_WR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.emit_last ? tlf_pkg::ST_EMIT_NL
                                                     : tlf_pkg::ST_EMIT_RD;
                end
            end
            tlf_pkg::ST_EMIT_NL:
            begin
                if (status.out_free)
                begin
                    cmd.nl_load = 1'b1;
                    state_next  = status.move_pending ? tlf_pkg::ST_MOVE_RD
                                                      : tlf_pkg::ST_IDLE;
                end
            end
            tlf_pkg::ST_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = tlf_pkg::ST_MOVE_WR;
            end
            tlf_pkg::ST_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = status.move_last ? tlf_pkg::ST_IDLE
                                               : tlf_pkg::ST_MOVE_RD;
            end
            default:
            begin
                state_next = tlf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tlf_datapath.sv =====
`default_nettype none

module tlf_datapath #(
    parameter int LINE_WIDTH = 32,
    parameter int TAB_STEP   = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    in_char,
    input  wire logic          end_of_input,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_char,
    output logic               last,
    input  wire tlf_pkg::cmd_t cmd,
    output tlf_pkg::status_t   status
);

    localparam int COL_W  = $clog2(LINE_WIDTH + 1);
    localparam int ADDR_W = $clog2(LINE_WIDTH);
    localparam int PH_W   = (TAB_STEP > 1) ? $clog2(TAB_STEP) : 1;

    localparam logic [COL_W-1:0]  LW_C      = COL_W'(LINE_WIDTH);
    localparam logic [COL_W-1:0]  LW_LAST_C = COL_W'(LINE_WIDTH - 1);
    localparam logic [ADDR_W-1:0] LB_TOP_C  = ADDR_W'(LINE_WIDTH - 1);
    localparam logic [PH_W-1:0]   PH_LAST_C = PH_W'(TAB_STEP - 1);

    logic [7:0] mem [LINE_WIDTH];
    logic [7:0] rd_data_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [ADDR_W-1:0] lb_reg, lb_next;
    logic              lb_valid_reg, lb_valid_next;
    logic [COL_W-1:0]  len_reg, len_next;
    logic [COL_W-1:0]  idx_reg, idx_next;
    logic              move_reg, move_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              last_reg, last_next;

    logic              is_eoi, is_tab, is_nl, is_char;
    logic [COL_W-1:0]  col_inc;
    logic [PH_W-1:0]   phase_inc;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic              lb_hit;
    logic [ADDR_W-1:0] lb_eff;
    logic              lb_eff_valid;
    logic              fold_move;

    assign is_eoi    = end_of_input;
    assign is_tab    = !end_of_input && (in_char == tlf_pkg::CH_TAB);
    assign is_nl     = !end_of_input && (in_char == tlf_pkg::CH_NEWLINE);
    assign is_char   = !is_eoi && !is_tab && !is_nl;
    assign col_inc   = col_reg + COL_W'(1);
    assign phase_inc = (phase_reg == PH_LAST_C) ? '0 : phase_reg + PH_W'(1);

    assign wr_en   = (cmd.accept && is_char) || cmd.fill_step || cmd.move_wr;
    assign wr_data = cmd.fill_step ? tlf_pkg::CH_BLANK
                   : cmd.move_wr   ? rd_data_reg
                                   : in_char;
    assign rd_en   = cmd.emit_rd || cmd.move_rd;

    // The written byte becomes the last blank of the line unless it sits at index 0.
    assign lb_hit       = wr_en && (wr_data == tlf_pkg::CH_BLANK) && (col_reg != '0);
    assign lb_eff       = lb_hit ? col_reg[ADDR_W-1:0] : lb_reg;
    assign lb_eff_valid = lb_hit || lb_valid_reg;
    assign fold_move    = lb_eff_valid && (lb_eff != LB_TOP_C);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[col_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        col_next       = col_reg;
        phase_next     = phase_reg;
        lb_next        = lb_reg;
        lb_valid_next  = lb_valid_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        move_next      = move_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.accept && (is_eoi || is_nl))
        begin
            len_next      = col_reg;
            idx_next      = '0;
            col_next      = '0;
            phase_next    = '0;
            lb_valid_next = 1'b0;
            move_next     = 1'b0;
        end

        if ((cmd.accept && is_char) || cmd.fill_step || cmd.move_wr)
        begin
            if (col_inc == LW_C)
            begin
                // Full: a char folds at an earlier last blank; all else emits whole.
                if (cmd.accept && fold_move)
                begin
                    len_next  = COL_W'(lb_eff) + COL_W'(1);
                    move_next = 1'b1;
                end
                else
                begin
                    len_next  = LW_C;
                    move_next = 1'b0;
                end
                idx_next      = '0;
                col_next      = '0;
                phase_next    = '0;
                lb_valid_next = 1'b0;
            end
            else
            begin
                col_next      = col_inc;
                phase_next    = phase_inc;
                lb_next       = lb_eff;
                lb_valid_next = lb_eff_valid;
            end
        end

        if (cmd.move_wr)
        begin
            idx_next = idx_reg + COL_W'(1);
        end

        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = rd_data_reg;
            last_next      = 1'b0;
            idx_next       = idx_reg + COL_W'(1);
        end

        if (cmd.nl_load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = tlf_pkg::CH_NEWLINE;
            last_next      = 1'b1;
            // The remainder starts right after the fold point.
            idx_next       = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            phase_reg     <= '0;
            lb_valid_reg  <= 1'b0;
            move_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            lb_valid_reg  <= lb_valid_next;
            move_reg      <= move_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lb_reg       <= lb_next;
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        status.in_eoi       = is_eoi;
        status.in_tab       = is_tab;
        status.in_nl        = is_nl;
        status.line_empty   = (col_reg == '0);
        status.col_full     = (col_inc == LW_C);
        status.fill_end     = (col_inc == LW_C) || (phase_inc == '0);
        status.emit_last    = (idx_reg == len_reg - COL_W'(1));
        status.move_last    = (idx_reg == LW_LAST_C);
        status.move_pending = move_reg;
        status.out_free     = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== rtl/text_line_folder_top.sv =====
// Text line folder. Each input request carries one character byte, or an
// end-of-input mark, and the block folds the stream into lines of at most
// LINE_WIDTH characters, expanding tabs to blanks up to the next TAB_STEP stop.
// Both channels use valid and stall; a request moves at a rising edge where
// valid is high and stall is low. Output requests carry one byte each, and
// last is high on the final byte (always a newline) that an input caused.
// Inputs that only extend the line produce no output at all.
// A tab stores blanks one by one up to the next stop or the end of the line.
// A line leaves with one line store read and one output load per byte, then
// the newline. A fold that leaves characters behind then copies them to the
// front, one read and one write each through the single line store port pair.
// The input stalls while a tab is filled or a line is emitted or moved. When the
// receiver stalls, the output register holds its byte and the sequencer waits.
// Reset clears the column, clears the output valid and returns to idle; the
// line store itself is not cleared, since only written entries are read.
`default_nettype none

module text_line_folder_top #(
    parameter int LINE_WIDTH = 32,
    parameter int TAB_STEP   = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_char,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_char,
    output logic            last
);

    tlf_pkg::cmd_t    cmd;
    tlf_pkg::status_t status;

    // Sequencer: decides the work for each input and paces the output.
    tlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Line store, column tracking and the output register.
    tlf_datapath #(
        .LINE_WIDTH (LINE_WIDTH),
        .TAB_STEP   (TAB_STEP)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_char      (in_char),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last         (last),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire
